// ----- sv/ppc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

    // Default number of CORDIC rotations and fixed number of square-root digits.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int SQRT_STEPS = 17;

    // Angle constants in 1/4096 rad and in the 2^-20 rad CORDIC scale.
    localparam logic signed [19:0] ANG_PI = 20'sd12868;
    localparam logic signed [19:0] ANG_2PI = 20'sd25736;
    localparam logic signed [24:0] PI_FINE = 25'sd3294199;

    // Output limits.
    localparam logic signed [33:0] V_LIM = 34'sd1229;
    localparam logic signed [36:0] W_LIM = 37'sd12288;

    // Register indexes.
    localparam logic [2:0] REG_GOAL_X = 3'd0;
    localparam logic [2:0] REG_GOAL_Y = 3'd1;
    localparam logic [2:0] REG_GOAL_HEADING = 3'd2;
    localparam logic [2:0] REG_GAIN_DISTANCE = 3'd3;
    localparam logic [2:0] REG_GAIN_BEARING = 3'd4;
    localparam logic [2:0] REG_GAIN_HEADING = 3'd5;
    localparam logic [2:0] REG_RUN_ENABLE = 3'd6;
    localparam logic [2:0] REG_ARRIVE_RADIUS = 3'd7;

    // Configuration register set.
    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic signed [14:0] goal_heading;
        logic signed [15:0] gain_distance;
        logic signed [15:0] gain_bearing;
        logic signed [15:0] gain_heading;
        logic               run_enable;
        logic        [15:0] arrive_radius;
    } ppc_cfg_t;

    // One request as it travels through the rotation and root stages.
    typedef struct packed {
        logic               valid;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [24:0] cz;
        logic               zero;
        logic        [33:0] rad;
        logic        [19:0] rem;
        logic        [16:0] root;
        logic signed [15:0] ph;
        logic               clr;
        logic               reached;
    } ppc_iter_t;

    // Arctangent of 2^-i in 2^-20 rad.
    function automatic logic signed [24:0] atan_fine(input int idx);
        logic signed [24:0] r;
        case (idx)
            0: r = 25'sd823550;
            1: r = 25'sd486170;
            2: r = 25'sd256879;
            3: r = 25'sd130396;
            4: r = 25'sd65451;
            5: r = 25'sd32757;
            6: r = 25'sd16383;
            7: r = 25'sd8192;
            8: r = 25'sd4096;
            9: r = 25'sd2048;
            10: r = 25'sd1024;
            11: r = 25'sd512;
            12: r = 25'sd256;
            13: r = 25'sd128;
            14: r = 25'sd64;
            15: r = 25'sd32;
            16: r = 25'sd16;
            17: r = 25'sd8;
            18: r = 25'sd4;
            19: r = 25'sd2;
            20: r = 25'sd1;
            default: r = 25'sd0;
        endcase
        return r;
    endfunction

    // Wrap an angle into [-pi, pi]; inputs stay within seven times pi of zero.
    function automatic logic signed [19:0] wrap_angle(input logic signed [19:0] a);
        logic signed [19:0] r;
        r = a;
        for (int k = 0; k < 3; k++) begin
            if (r > ANG_PI) begin
                r = r - ANG_2PI;
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (r < -ANG_PI) begin
                r = r + ANG_2PI;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/polar_pose_controller.sv -----
// Polar-coordinate pose controller for a unicycle robot: each pose request
// (x, y, heading) yields a linear speed, a turn rate and a sticky goal-reached
// flag. The block accepts one request per clock while the result side is not
// stalled and returns results in order; the depth is set by the longer of the
// chain of one-rotation CORDIC stages and the 17 one-digit square-root stages,
// which run side by side, plus three front stages (offsets, squares, distance)
// and four back stages (angle wrapping, gain products, rounding and clamping).
// Backpressure on the result side stalls the whole pipeline; nothing is lost or
// repeated.
`timescale 1ns / 1ps
`default_nettype none

module polar_pose_controller #(
    parameter int CORDIC_STAGES = ppc_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Pose requests. tdata: pose_x [15:0], pose_y [31:16], pose_heading [47:32].
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    // tuser: clear_reached [0].
    input  wire logic        s_tuser,
    // Commands. tdata: lin_speed [11:0], turn_rate [26:12], zero [31:27].
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    // tuser: at_goal [0].
    output logic             m_tuser,
    // Configuration writes.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    localparam int NSTAGE = (CORDIC_STAGES > ppc_pkg::SQRT_STEPS) ?
                            CORDIC_STAGES : ppc_pkg::SQRT_STEPS;

    // Configuration registers.
    ppc_pkg::ppc_cfg_t cfg_reg;
    logic              flag_clear;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_x <= '0;
            cfg_reg.goal_y <= '0;
            cfg_reg.goal_heading <= '0;
            cfg_reg.gain_distance <= 16'sd4096;
            cfg_reg.gain_bearing <= 16'sd6144;
            cfg_reg.gain_heading <= -16'sd2048;
            cfg_reg.run_enable <= 1'b0;
            cfg_reg.arrive_radius <= 16'd51;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ppc_pkg::REG_GOAL_X: cfg_reg.goal_x <= cfg_wdata;
                ppc_pkg::REG_GOAL_Y: cfg_reg.goal_y <= cfg_wdata;
                ppc_pkg::REG_GOAL_HEADING: cfg_reg.goal_heading <= cfg_wdata[14:0];
                ppc_pkg::REG_GAIN_DISTANCE: cfg_reg.gain_distance <= cfg_wdata;
                ppc_pkg::REG_GAIN_BEARING: cfg_reg.gain_bearing <= cfg_wdata;
                ppc_pkg::REG_GAIN_HEADING: cfg_reg.gain_heading <= cfg_wdata;
                ppc_pkg::REG_RUN_ENABLE: cfg_reg.run_enable <= cfg_wdata[0];
                ppc_pkg::REG_ARRIVE_RADIUS: cfg_reg.arrive_radius <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A new goal clears the arrival flag.
    assign flag_clear = cfg_we && (cfg_addr == ppc_pkg::REG_GOAL_X ||
                                   cfg_addr == ppc_pkg::REG_GOAL_Y ||
                                   cfg_addr == ppc_pkg::REG_GOAL_HEADING);

    // The whole pipeline moves when the output register is free or drained.
    logic adv;
    logic out_valid;

    assign adv = !out_valid || m_tready;
    assign s_tready = adv;

    ppc_pkg::ppc_iter_t stage [0:NSTAGE];

    ppc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (s_tvalid),
        .pose_x        (s_tdata[15:0]),
        .pose_y        (s_tdata[31:16]),
        .pose_heading  (s_tdata[47:32]),
        .clear_reached (s_tuser),
        .cfg           (cfg_reg),
        .st_out        (stage[0])
    );

    // Rotation and root-digit stages.
    for (genvar i = 0; i < NSTAGE; i++) begin : g_iter
        ppc_iter_stage #(
            .IDX           (i),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .st_in   (stage[i]),
            .st_out  (stage[i+1])
        );
    end

    logic signed [11:0] lin_speed;
    logic signed [14:0] turn_rate;
    logic               at_goal;

    ppc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .flag_clear   (flag_clear),
        .st_in        (stage[NSTAGE]),
        .cfg          (cfg_reg),
        .out_valid    (out_valid),
        .lin_speed    (lin_speed),
        .turn_rate    (turn_rate),
        .at_goal      (at_goal)
    );

    assign m_tvalid = out_valid;
    assign m_tdata = {5'd0, turn_rate, lin_speed};
    assign m_tuser = at_goal;

endmodule

`default_nettype wire

// ----- sv/ppc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppc_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic signed [15:0]   pose_x,
    input  wire logic signed [15:0]   pose_y,
    input  wire logic signed [15:0]   pose_heading,
    input  wire logic                 clear_reached,
    input  wire ppc_pkg::ppc_cfg_t    cfg,
    output ppc_pkg::ppc_iter_t        st_out
);

    // Stage one: offsets to the goal.
    logic               v1_reg;
    logic signed [16:0] dx1_reg, dy1_reg;
    logic signed [15:0] ph1_reg;
    logic               clr1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
        end
        if (adv) begin
            dx1_reg <= 17'(cfg.goal_x) - 17'(pose_x);
            dy1_reg <= 17'(cfg.goal_y) - 17'(pose_y);
            ph1_reg <= pose_heading;
            clr1_reg <= clear_reached;
        end
    end

    // Stage two: squares and the CORDIC start vector with half-plane fold.
    logic signed [33:0] sqx_full, sqy_full;
    logic        [31:0] rr_full;
    logic signed [33:0] x0, y0;
    logic signed [24:0] z0;

    assign sqx_full = dx1_reg * dx1_reg;
    assign sqy_full = dy1_reg * dy1_reg;
    assign rr_full = cfg.arrive_radius * cfg.arrive_radius;

    always_comb begin
        x0 = 34'(dx1_reg) <<< 14;
        y0 = 34'(dy1_reg) <<< 14;
        z0 = '0;
        if (x0 < 0) begin
            z0 = (y0 >= 0) ? ppc_pkg::PI_FINE : -ppc_pkg::PI_FINE;
            x0 = -x0;
            y0 = -y0;
        end
    end

    logic               v2_reg;
    logic        [32:0] sqx2_reg, sqy2_reg;
    logic        [31:0] rr2_reg;
    logic signed [33:0] x2_reg, y2_reg;
    logic signed [24:0] z2_reg;
    logic               zero2_reg;
    logic signed [15:0] ph2_reg;
    logic               clr2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            sqx2_reg <= sqx_full[32:0];
            sqy2_reg <= sqy_full[32:0];
            rr2_reg <= rr_full;
            x2_reg <= x0;
            y2_reg <= y0;
            z2_reg <= z0;
            zero2_reg <= (dx1_reg == '0) && (dy1_reg == '0);
            ph2_reg <= ph1_reg;
            clr2_reg <= clr1_reg;
        end
    end

    // Stage three: squared distance, arrival test, root iteration start.
    ppc_pkg::ppc_iter_t st_next, st_reg;
    logic [33:0] d2;

    assign d2 = 34'(sqx2_reg) + 34'(sqy2_reg);

    always_comb begin
        st_next.valid = v2_reg;
        st_next.cx = x2_reg;
        st_next.cy = y2_reg;
        st_next.cz = z2_reg;
        st_next.zero = zero2_reg;
        st_next.rad = d2;
        st_next.rem = '0;
        st_next.root = '0;
        st_next.ph = ph2_reg;
        st_next.clr = clr2_reg;
        st_next.reached = (d2 <= 34'(rr2_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (adv) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

`default_nettype wire

// ----- sv/ppc_iter_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppc_iter_stage #(
    parameter int IDX = 0,
    parameter int CORDIC_STAGES = ppc_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire ppc_pkg::ppc_iter_t st_in,
    output ppc_pkg::ppc_iter_t      st_out
);

    ppc_pkg::ppc_iter_t st_next, st_reg;
    logic [19:0] rem_sh;
    logic [19:0] trial;

    // One vectoring rotation and one square-root digit.
    always_comb begin
        st_next = st_in;
        rem_sh = {st_in.rem[17:0], st_in.rad[33:32]};
        trial = {1'b0, st_in.root, 2'b01};
        if (IDX < CORDIC_STAGES) begin
            if (st_in.cy < 0) begin
                st_next.cx = st_in.cx - (st_in.cy >>> IDX);
                st_next.cy = st_in.cy + (st_in.cx >>> IDX);
                st_next.cz = st_in.cz - ppc_pkg::atan_fine(IDX);
            end else begin
                st_next.cx = st_in.cx + (st_in.cy >>> IDX);
                st_next.cy = st_in.cy - (st_in.cx >>> IDX);
                st_next.cz = st_in.cz + ppc_pkg::atan_fine(IDX);
            end
        end
        if (IDX < ppc_pkg::SQRT_STEPS) begin
            st_next.rad = st_in.rad << 2;
            if (rem_sh >= trial) begin
                st_next.rem = rem_sh - trial;
                st_next.root = {st_in.root[15:0], 1'b1};
            end else begin
                st_next.rem = rem_sh;
                st_next.root = {st_in.root[15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (adv) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

`default_nettype wire

// ----- sv/ppc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppc_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire logic               flag_clear,
    input  wire ppc_pkg::ppc_iter_t st_in,
    input  wire ppc_pkg::ppc_cfg_t  cfg,
    output logic                    out_valid,
    output logic signed [11:0]      lin_speed,
    output logic signed [14:0]      turn_rate,
    output logic                    at_goal
);

    // Stage one: round the angle and form the bearing error.
    logic signed [24:0] z_rnd;
    logic signed [16:0] ang;
    logic signed [19:0] alpha_w;

    assign z_rnd = st_in.cz + 25'sd128;
    assign ang = st_in.zero ? 17'sd0 : z_rnd[24:8];
    assign alpha_w = ppc_pkg::wrap_angle(20'(ang) - 20'(st_in.ph));

    logic               v1_reg;
    logic signed [15:0] alpha1_reg;
    logic signed [19:0] hd1_reg;
    logic        [16:0] rho1_reg;
    logic               clr1_reg, reached1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= st_in.valid;
        end
        if (adv) begin
            alpha1_reg <= alpha_w[15:0];
            hd1_reg <= 20'(cfg.goal_heading) - 20'(st_in.ph);
            rho1_reg <= st_in.root;
            clr1_reg <= st_in.clr;
            reached1_reg <= st_in.reached;
        end
    end

    // Stage two: heading error and the distance product.
    logic signed [19:0] beta_w;
    logic signed [33:0] linp_full;

    assign beta_w = ppc_pkg::wrap_angle(hd1_reg - 20'(alpha1_reg));
    assign linp_full = 34'(cfg.gain_distance) * 34'($signed({1'b0, rho1_reg}));

    logic               v2_reg;
    logic signed [15:0] alpha2_reg, beta2_reg;
    logic signed [33:0] linp2_reg;
    logic               clr2_reg, reached2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            alpha2_reg <= alpha1_reg;
            beta2_reg <= beta_w[15:0];
            linp2_reg <= linp_full;
            clr2_reg <= clr1_reg;
            reached2_reg <= reached1_reg;
        end
    end

    // Stage three: angle products, linear speed rounding and clamp.
    logic signed [31:0] pa_full, pb_full;
    logic signed [33:0] lin_rnd, lin_sh, lin_cl;

    assign pa_full = cfg.gain_bearing * alpha2_reg;
    assign pb_full = cfg.gain_heading * beta2_reg;
    assign lin_rnd = linp2_reg + 34'sd512;
    assign lin_sh = lin_rnd >>> 10;

    always_comb begin
        if (lin_sh > ppc_pkg::V_LIM) begin
            lin_cl = ppc_pkg::V_LIM;
        end else if (lin_sh < -ppc_pkg::V_LIM) begin
            lin_cl = -ppc_pkg::V_LIM;
        end else begin
            lin_cl = lin_sh;
        end
    end

    logic               v3_reg;
    logic signed [31:0] pa3_reg, pb3_reg;
    logic signed [11:0] lin3_reg;
    logic               clr3_reg, reached3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            pa3_reg <= pa_full;
            pb3_reg <= pb_full;
            lin3_reg <= lin_cl[11:0];
            clr3_reg <= clr2_reg;
            reached3_reg <= reached2_reg;
        end
    end

    // Stage four: turn rate, run gating, sticky flag and the output register.
    logic signed [36:0] w_sum, w_sh, w_cl;
    logic               flag_reg, flag_next;
    logic               out_valid_reg;
    logic signed [11:0] lin_reg;
    logic signed [14:0] turn_reg;
    logic               reached_reg;

    assign w_sum = 37'(pa3_reg) + 37'(pb3_reg) + 37'sd2048;
    assign w_sh = w_sum >>> 12;

    always_comb begin
        if (w_sh > ppc_pkg::W_LIM) begin
            w_cl = ppc_pkg::W_LIM;
        end else if (w_sh < -ppc_pkg::W_LIM) begin
            w_cl = -ppc_pkg::W_LIM;
        end else begin
            w_cl = w_sh;
        end
        flag_next = (flag_reg && !clr3_reg) || (cfg.run_enable && reached3_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            flag_reg <= 1'b0;
        end else begin
            if (adv) begin
                out_valid_reg <= v3_reg;
            end
            if (flag_clear) begin
                flag_reg <= 1'b0;
            end else if (adv && v3_reg) begin
                flag_reg <= flag_next;
            end
        end
        if (adv) begin
            lin_reg <= cfg.run_enable ? lin3_reg : 12'sd0;
            turn_reg <= cfg.run_enable ? w_cl[14:0] : 15'sd0;
            reached_reg <= flag_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign lin_speed = lin_reg;
    assign turn_rate = turn_reg;
    assign at_goal = reached_reg;

endmodule

`default_nettype wire

// ----- sv/ppc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Linear speed stays within its clamp.
    a_lin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[11:0]) <= 12'sd1229 &&
                      $signed(m_tdata[11:0]) >= -12'sd1229))
        else $error("linear speed out of range");

    // Turn rate stays within its clamp and the pad bits are zero.
    a_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[26:12]) <= 15'sd12288 &&
                      $signed(m_tdata[26:12]) >= -15'sd12288 &&
                      m_tdata[31:27] == 5'd0))
        else $error("turn rate out of range");

endmodule

bind polar_pose_controller ppc_checker u_ppc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- sim/tb_polar_pose_controller.sv -----
`timescale 1ns / 1ps

module tb_polar_pose_controller;

    localparam int LATENCY = 24;
    localparam int CYCLE_LIMIT = 400000;

    // Clock and reset.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Block ports.
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [31:0] m_tdata;
    wire         m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    polar_pose_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Expected command for one pose.
    typedef struct packed {
        logic signed [11:0] lin_speed;
        logic signed [14:0] turn_rate;
        logic               reached;
    } command_t;

    // Predictor copy of the configuration and the sticky flag.
    longint goal_x, goal_y, goal_hdg, k_dist, k_bear, k_hdg, radius;
    bit     running;
    bit     arrived;
    command_t expected_cmds[$];
    int     errors = 0;
    int     cycles = 0;
    bit     hold_off = 1'b0;
    int     hold_len = 0;
    bit     long_hold_req = 1'b0;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        r = 0;
        for (longint b = 64'sd1 << 17; b > 0; b = b >> 1) begin
            if ((r + b) * (r + b) <= n) begin
                r = r + b;
            end
        end
        return r;
    endfunction

    function automatic longint wrap_pi(longint a);
        while (a > 12868) a -= 25736;
        while (a < -12868) a += 25736;
        return a;
    endfunction

    // Vectoring-mode arctangent, result in 1/4096 rad.
    function automatic longint bearing_of(longint dy, longint dx);
        longint x, y, z, xs, ys;
        x = dx * 16384;
        y = dy * 16384;
        z = 0;
        if (dx == 0 && dy == 0) begin
            return 0;
        end
        if (x < 0) begin
            z = (y >= 0) ? 3294199 : -3294199;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ppc_pkg::CORDIC_STAGES_DEF; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (y < 0) begin
                x -= ys; y += xs; z -= ppc_pkg::atan_fine(i);
            end else begin
                x += ys; y -= xs; z += ppc_pkg::atan_fine(i);
            end
        end
        return shr(z + 128, 8);
    endfunction

    function automatic longint clip(longint v, longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    function automatic command_t predict_command(logic signed [15:0] px, logic signed [15:0] py,
                                                 logic signed [15:0] ph, logic clr);
        command_t c;
        longint dx, dy, d2, rho, alpha, beta, v, w;
        dx = goal_x - px;
        dy = goal_y - py;
        d2 = dx * dx + dy * dy;
        v = 0;
        w = 0;
        if (clr) arrived = 1'b0;
        if (running) begin
            if (d2 <= radius * radius) arrived = 1'b1;
            rho = root_floor(d2);
            alpha = wrap_pi(bearing_of(dy, dx) - ph);
            beta = wrap_pi(goal_hdg - ph - alpha);
            v = clip(shr(k_dist * rho + 512, 10), 1229);
            w = clip(shr(k_bear * alpha + k_hdg * beta + 2048, 12), 12288);
        end
        c.lin_speed = v[11:0];
        c.turn_rate = w[14:0];
        c.reached = arrived;
        return c;
    endfunction

    // Register write, mirrored in the predictor.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            ppc_pkg::REG_GOAL_X: begin goal_x = $signed(val); arrived = 1'b0; end
            ppc_pkg::REG_GOAL_Y: begin goal_y = $signed(val); arrived = 1'b0; end
            ppc_pkg::REG_GOAL_HEADING: begin
                goal_hdg = $signed(val[14:0]);
                arrived = 1'b0;
            end
            ppc_pkg::REG_GAIN_DISTANCE: k_dist = $signed(val);
            ppc_pkg::REG_GAIN_BEARING: k_bear = $signed(val);
            ppc_pkg::REG_GAIN_HEADING: k_hdg = $signed(val);
            ppc_pkg::REG_RUN_ENABLE: running = val[0];
            ppc_pkg::REG_ARRIVE_RADIUS: radius = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every command is back and the pipeline is drained.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Send one pose request; random gap first unless told not to.
    task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [15:0] ph, logic clr, bit gaps);
        int gap;
        gap = 0;
        if (gaps) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) gap = 0;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ph, py, px};
        s_tuser <= clr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_cmds.push_back(predict_command(px, py, ph, clr));
    endtask

    function automatic logic signed [15:0] rand_heading();
        return $signed(16'($urandom_range(0, 51472))) - 16'sd25736;
    endfunction

    // Random pose: one in three near the goal so arrival and small offsets occur.
    task automatic send_random_pose(bit gaps);
        logic signed [15:0] px, py;
        if ($urandom_range(0, 2) == 0) begin
            px = 16'(goal_x + $signed(16'($urandom_range(0, 160))) - 80);
            py = 16'(goal_y + $signed(16'($urandom_range(0, 160))) - 80);
        end else begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
        send_pose(px, py, rand_heading(), $urandom_range(0, 7) == 0, gaps);
    endtask

    task automatic test_stopped();
        send_pose(16'sd100, -16'sd200, 16'sd0, 1'b0, 1'b1);
        send_pose(-16'sd32768, 16'sd32767, 16'sd25736, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_directed();
        write_reg(ppc_pkg::REG_RUN_ENABLE, 16'd1);
        send_pose(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
        send_pose(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
        send_pose(16'sd30, 16'sd40, 16'sd0, 1'b0, 1'b1);
        send_pose(16'sd31, 16'sd40, 16'sd0, 1'b1, 1'b1);
        send_pose(-16'sd32768, -16'sd32768, -16'sd25736, 1'b1, 1'b1);
        send_pose(16'sd32767, 16'sd32767, 16'sd25736, 1'b0, 1'b1);
        send_pose(16'sd32767, -16'sd32768, 16'sd12869, 1'b0, 1'b1);
        send_pose(-16'sd32768, 16'sd0, -16'sd12869, 1'b0, 1'b1);
        send_pose(16'sd1000, 16'sd0, 16'sd0, 1'b0, 1'b1);
        send_pose(16'sd0, 16'sd1000, -16'sd1, 1'b0, 1'b1);
        send_pose(16'sd0, -16'sd1000, 16'sd1, 1'b0, 1'b1);
        send_pose(16'h5555, 16'haaaa, 16'h5555, 1'b0, 1'b1);
        send_pose(16'haaaa, 16'h5555, 16'shaaaa, 1'b0, 1'b1);
        drain();
        // Sticky flag survives stop, then is cleared by a request.
        write_reg(ppc_pkg::REG_RUN_ENABLE, 16'd0);
        send_pose(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
        send_pose(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
        drain();
        write_reg(ppc_pkg::REG_RUN_ENABLE, 16'd1);
    endtask

    // Random poses under one register setting.
    task automatic test_random_phase(int n, logic [15:0] gx, logic [15:0] gy,
                                     logic [15:0] gh, logic [15:0] kd, logic [15:0] kb,
                                     logic [15:0] kh, logic [15:0] rad, bit run);
        write_reg(ppc_pkg::REG_GOAL_X, gx);
        write_reg(ppc_pkg::REG_GOAL_Y, gy);
        write_reg(ppc_pkg::REG_GOAL_HEADING, gh);
        write_reg(ppc_pkg::REG_GAIN_DISTANCE, kd);
        write_reg(ppc_pkg::REG_GAIN_BEARING, kb);
        write_reg(ppc_pkg::REG_GAIN_HEADING, kh);
        write_reg(ppc_pkg::REG_ARRIVE_RADIUS, rad);
        write_reg(ppc_pkg::REG_RUN_ENABLE, {15'd0, run});
        for (int i = 0; i < n; i++) send_random_pose(1'b1);
        drain();
    endtask

    // Receiver holds off while the sender keeps offering requests.
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        for (int i = 0; i < 80; i++) send_random_pose(1'b0);
        drain();
    endtask

    // Result side: random stalls, compare each command with the oldest expectation.
    always @(posedge aclk) begin
        command_t got, want;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.lin_speed = m_tdata[11:0];
            got.turn_rate = m_tdata[26:12];
            got.reached = m_tuser;
            if (expected_cmds.size() == 0) begin
                $display("%0t: unexpected command %h", $time, got);
                errors++;
            end else begin
                want = expected_cmds.pop_front();
                if (got.lin_speed !== want.lin_speed)
                    $display("%0t: lin_speed expected %0d actual %0d", $time,
                             want.lin_speed, got.lin_speed);
                if (got.turn_rate !== want.turn_rate)
                    $display("%0t: turn_rate expected %0d actual %0d", $time,
                             want.turn_rate, got.turn_rate);
                if (got.reached !== want.reached)
                    $display("%0t: at_goal expected %0b actual %0b", $time,
                             want.reached, got.reached);
                if (got !== want) errors++;
            end
        end
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            m_tready <= 1'b0;
            hold_off <= 1'b1;
            hold_len <= 300;
        end else if (hold_off) begin
            m_tready <= 1'b0;
            hold_len <= hold_len - 1;
            if (hold_len <= 1) hold_off <= 1'b0;
        end else if ((cycles / 2000) % 3 == 2) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 49) == 0) begin
            hold_off <= 1'b1;
            hold_len <= $urandom_range(10, 40);
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Run-length guard.
    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        goal_x = 0; goal_y = 0; goal_hdg = 0;
        k_dist = 4096; k_bear = 6144; k_hdg = -2048;
        running = 1'b0; radius = 51; arrived = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_stopped();
        test_directed();
        test_random_phase(300, 16'd0, 16'd0, 16'd0, 16'd4096, 16'd6144, 16'hf800, 16'd51, 1'b1);
        test_random_phase(200, 16'h7fff, 16'h8000, 16'd12868, 16'h7fff, 16'h7fff, 16'h7fff,
                          16'd0, 1'b1);
        test_random_phase(200, 16'h8000, 16'h7fff, 16'h4dbc, 16'h8000, 16'h8000, 16'h8000,
                          16'hffff, 1'b1);
        test_backpressure();
        test_random_phase(100, 16'h1234, 16'hedcb, 16'h0400, 16'd2000, 16'hf000, 16'd3000,
                          16'd200, 1'b0);
        test_random_phase(300, 16'h0100, 16'hff00, 16'h7c00, 16'd8192, 16'd4096, 16'hf000,
                          16'd500, 1'b1);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
